@@ rtl/core/mpme_pkg.sv @@
package mpme_pkg;

  localparam int unsigned NUM_BUFFERS_DEF = 16;
  localparam int unsigned NUM_TASKS_DEF   = 8;
  localparam int unsigned DATA_WIDTH_DEF  = 32;

  localparam int unsigned ID_W   = 3;
  localparam int unsigned SIZE_W = 8;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NO_BUF = 2'd1,
    ST_NO_MSG = 2'd2
  } status_t;

  typedef enum logic {
    REQ_SEND = 1'b0,
    REQ_RECV = 1'b1
  } req_t;

endpackage

@@ rtl/core/mpme_link_ram.sv @@
module mpme_link_ram #(
  parameter int unsigned NUM_BUFFERS = mpme_pkg::NUM_BUFFERS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             rd_en,
  input  logic [$clog2(NUM_BUFFERS)-1:0]   rd_addr,
  output logic [$clog2(NUM_BUFFERS+1)-1:0] rd_data,
  input  logic                             wr_en,
  input  logic [$clog2(NUM_BUFFERS)-1:0]   wr_addr,
  input  logic [$clog2(NUM_BUFFERS+1)-1:0] wr_data
);

  localparam int unsigned BUF_W  = $clog2(NUM_BUFFERS);
  localparam int unsigned LINK_W = $clog2(NUM_BUFFERS + 1);

  logic [LINK_W-1:0]      mem [NUM_BUFFERS];
  logic [NUM_BUFFERS-1:0] vld_r;
  logic                   rd_vld_r;
  logic [LINK_W-1:0]      rd_q_r;
  logic [BUF_W-1:0]       rd_addr_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r    <= mem[rd_addr];
      rd_addr_r <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  // unwritten entry: reset chain, buffer i links to i+1, last to null
  assign rd_data = rd_vld_r ? rd_q_r : (LINK_W'({1'b0, rd_addr_r}) + LINK_W'(1));

endmodule

@@ rtl/core/message_pool_mailbox_engine_unit.sv @@
// Channel   Direction  Handshake             Payload
// in_       input      in_valid / in_stall   req_type, task_id, peer_id, msg_size, payload
// out_      output     out_valid / out_stall status, rx_size, rx_data
//
// One request at a time; in_stall is high from accept until the result is loaded.
// Send: S_SEND, then S_SEND_LINK when the queue held entries, to the result register.
// Receive: head read, then a one-read-per-cycle link walk over the mailbox entries.
// A held result stalls only the final load; the request itself is worked meanwhile.
// Synchronous reset; link memory starts chained through per-entry valid bits.
module message_pool_mailbox_engine_unit #(
  parameter int unsigned NUM_BUFFERS = mpme_pkg::NUM_BUFFERS_DEF,
  parameter int unsigned NUM_TASKS   = mpme_pkg::NUM_TASKS_DEF,
  parameter int unsigned DATA_WIDTH  = mpme_pkg::DATA_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_req_type,
  input  logic [mpme_pkg::ID_W-1:0]   in_task_id,
  input  logic [mpme_pkg::ID_W-1:0]   in_peer_id,
  input  logic [mpme_pkg::SIZE_W-1:0] in_msg_size,
  input  logic [DATA_WIDTH-1:0]       in_payload,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  out_status,
  output logic [mpme_pkg::SIZE_W-1:0] out_rx_size,
  output logic [DATA_WIDTH-1:0]       out_rx_data
);

  localparam int unsigned BUF_W  = $clog2(NUM_BUFFERS);
  localparam int unsigned LINK_W = $clog2(NUM_BUFFERS + 1);
  localparam int unsigned TASK_W = $clog2(NUM_TASKS);
  localparam int unsigned ID_W   = mpme_pkg::ID_W;
  localparam int unsigned SIZE_W = mpme_pkg::SIZE_W;
  localparam int unsigned MSG_W  = ID_W + SIZE_W + DATA_WIDTH;
  localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(NUM_BUFFERS);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEND,
    S_SEND_LINK,
    S_RCV_HEAD,
    S_WALK,
    S_UNLINK,
    S_FREE_CUR,
    S_FREE_TAIL,
    S_OUT
  } state_t;

  state_t                state_r, state_nxt;
  logic                  req_type_r, req_type_nxt;
  logic [ID_W-1:0]       task_r, task_nxt;
  logic [ID_W-1:0]       peer_r, peer_nxt;
  logic [SIZE_W-1:0]     size_r, size_nxt;
  logic [DATA_WIDTH-1:0] data_r, data_nxt;
  logic [LINK_W-1:0]     free_head_r, free_head_nxt;
  logic [LINK_W-1:0]     free_tail_r, free_tail_nxt;
  logic [LINK_W-1:0]     qhead_r, qhead_nxt;
  logic [LINK_W-1:0]     qtail_r, qtail_nxt;
  logic [LINK_W-1:0]     prev_r, prev_nxt;
  logic [LINK_W-1:0]     cur_r, cur_nxt;
  logic [LINK_W-1:0]     nlink_r, nlink_nxt;
  mpme_pkg::status_t     status_r, status_nxt;
  logic [SIZE_W-1:0]     rsize_r, rsize_nxt;
  logic [DATA_WIDTH-1:0] rdata_r, rdata_nxt;
  logic                  out_valid_r, out_valid_nxt;
  mpme_pkg::status_t     out_status_r, out_status_nxt;
  logic [SIZE_W-1:0]     out_rx_size_r, out_rx_size_nxt;
  logic [DATA_WIDTH-1:0] out_rx_data_r, out_rx_data_nxt;

  logic                  lnk_re, lnk_we;
  logic [BUF_W-1:0]      lnk_ra, lnk_wa;
  logic [LINK_W-1:0]     lnk_wd, lnk_rd;

  logic [MSG_W-1:0]      msg_mem [NUM_BUFFERS];
  logic                  msg_re, msg_we;
  logic [BUF_W-1:0]      msg_ra, msg_wa;
  logic [MSG_W-1:0]      msg_wd, msg_q_r;
  logic [ID_W-1:0]       msg_rd_sender;
  logic [SIZE_W-1:0]     msg_rd_size;
  logic [DATA_WIDTH-1:0] msg_rd_data;

  logic [2*LINK_W-1:0]   q_mem [NUM_TASKS];
  logic [NUM_TASKS-1:0]  q_vld_r;
  logic                  q_rd_vld_r;
  logic [2*LINK_W-1:0]   q_q_r;
  logic                  q_re, q_we;
  logic [TASK_W-1:0]     q_ra, q_wa;
  logic [2*LINK_W-1:0]   q_wd;
  logic [LINK_W-1:0]     q_rd_head, q_rd_tail;

  logic                  ids_ok;

  mpme_link_ram #(
    .NUM_BUFFERS(NUM_BUFFERS)
  ) u_link_ram (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_en  (lnk_re),
    .rd_addr(lnk_ra),
    .rd_data(lnk_rd),
    .wr_en  (lnk_we),
    .wr_addr(lnk_wa),
    .wr_data(lnk_wd)
  );

  always_ff @(posedge clk) begin
    if (msg_we) begin
      msg_mem[msg_wa] <= msg_wd;
    end
    if (msg_re) begin
      msg_q_r <= msg_mem[msg_ra];
    end
    if (q_we) begin
      q_mem[q_wa] <= q_wd;
    end
    if (q_re) begin
      q_q_r <= q_mem[q_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_vld_r    <= '0;
      q_rd_vld_r <= 1'b0;
    end else begin
      if (q_we) begin
        q_vld_r[q_wa] <= 1'b1;
      end
      if (q_re) begin
        q_rd_vld_r <= q_vld_r[q_ra];
      end
    end
  end

  assign msg_rd_sender = msg_q_r[MSG_W-1 -: ID_W];
  assign msg_rd_size   = msg_q_r[DATA_WIDTH +: SIZE_W];
  assign msg_rd_data   = msg_q_r[DATA_WIDTH-1:0];
  assign q_rd_head     = q_rd_vld_r ? q_q_r[2*LINK_W-1 -: LINK_W] : LINK_NULL;
  assign q_rd_tail     = q_rd_vld_r ? q_q_r[LINK_W-1:0] : LINK_NULL;

  assign ids_ok = (32'(in_task_id) < NUM_TASKS) && (32'(in_peer_id) < NUM_TASKS);

  always_comb begin
    state_nxt       = state_r;
    req_type_nxt    = req_type_r;
    task_nxt        = task_r;
    peer_nxt        = peer_r;
    size_nxt        = size_r;
    data_nxt        = data_r;
    free_head_nxt   = free_head_r;
    free_tail_nxt   = free_tail_r;
    qhead_nxt       = qhead_r;
    qtail_nxt       = qtail_r;
    prev_nxt        = prev_r;
    cur_nxt         = cur_r;
    nlink_nxt       = nlink_r;
    status_nxt      = status_r;
    rsize_nxt       = rsize_r;
    rdata_nxt       = rdata_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_status_nxt  = out_status_r;
    out_rx_size_nxt = out_rx_size_r;
    out_rx_data_nxt = out_rx_data_r;
    lnk_re          = 1'b0;
    lnk_ra          = free_head_r[BUF_W-1:0];
    lnk_we          = 1'b0;
    lnk_wa          = cur_r[BUF_W-1:0];
    lnk_wd          = LINK_NULL;
    msg_re          = 1'b0;
    msg_ra          = cur_r[BUF_W-1:0];
    msg_we          = 1'b0;
    msg_wa          = free_head_r[BUF_W-1:0];
    msg_wd          = {task_r, size_r, data_r};
    q_re            = 1'b0;
    q_ra            = TASK_W'(in_peer_id);
    q_we            = 1'b0;
    q_wa            = TASK_W'(peer_r);
    q_wd            = {qhead_r, qtail_r};

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_type_nxt = in_req_type;
          task_nxt     = in_task_id;
          peer_nxt     = in_peer_id;
          size_nxt     = in_msg_size;
          data_nxt     = in_payload;
          rsize_nxt    = '0;
          rdata_nxt    = '0;
          if (!ids_ok) begin
            status_nxt = mpme_pkg::ST_NO_MSG;
            state_nxt  = S_OUT;
          end else if (in_req_type == mpme_pkg::REQ_SEND) begin
            q_re      = 1'b1;
            lnk_re    = 1'b1;
            state_nxt = S_SEND;
          end else begin
            q_re      = 1'b1;
            q_ra      = TASK_W'(in_task_id);
            state_nxt = S_RCV_HEAD;
          end
        end
      end
      S_SEND: begin
        if (free_head_r == LINK_NULL) begin
          status_nxt = mpme_pkg::ST_NO_BUF;
          state_nxt  = S_OUT;
        end else begin
          free_head_nxt = lnk_rd;
          if (lnk_rd == LINK_NULL) begin
            free_tail_nxt = LINK_NULL;
          end
          msg_we     = 1'b1;
          lnk_we     = 1'b1;
          lnk_wa     = free_head_r[BUF_W-1:0];
          lnk_wd     = LINK_NULL;
          q_we       = 1'b1;
          q_wd       = {(q_rd_head == LINK_NULL) ? free_head_r : q_rd_head, free_head_r};
          qtail_nxt  = q_rd_tail;
          cur_nxt    = free_head_r;
          status_nxt = mpme_pkg::ST_OK;
          if (q_rd_head != LINK_NULL && q_rd_tail != LINK_NULL) begin
            state_nxt = S_SEND_LINK;
          end else begin
            state_nxt = S_OUT;
          end
        end
      end
      S_SEND_LINK: begin
        lnk_we    = 1'b1;
        lnk_wa    = qtail_r[BUF_W-1:0];
        lnk_wd    = cur_r;
        state_nxt = S_OUT;
      end
      S_RCV_HEAD: begin
        qhead_nxt = q_rd_head;
        qtail_nxt = q_rd_tail;
        prev_nxt  = LINK_NULL;
        cur_nxt   = q_rd_head;
        if (q_rd_head == LINK_NULL) begin
          status_nxt = mpme_pkg::ST_NO_MSG;
          state_nxt  = S_OUT;
        end else begin
          lnk_re    = 1'b1;
          lnk_ra    = q_rd_head[BUF_W-1:0];
          msg_re    = 1'b1;
          msg_ra    = q_rd_head[BUF_W-1:0];
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        if (msg_rd_sender == peer_r) begin
          nlink_nxt = lnk_rd;
          rsize_nxt = msg_rd_size;
          rdata_nxt = msg_rd_data;
          state_nxt = S_UNLINK;
        end else begin
          prev_nxt = cur_r;
          cur_nxt  = lnk_rd;
          if (lnk_rd == LINK_NULL) begin
            status_nxt = mpme_pkg::ST_NO_MSG;
            state_nxt  = S_OUT;
          end else begin
            lnk_re = 1'b1;
            lnk_ra = lnk_rd[BUF_W-1:0];
            msg_re = 1'b1;
            msg_ra = lnk_rd[BUF_W-1:0];
          end
        end
      end
      S_UNLINK: begin
        if (prev_r != LINK_NULL) begin
          lnk_we = 1'b1;
          lnk_wa = prev_r[BUF_W-1:0];
          lnk_wd = nlink_r;
        end
        q_we       = 1'b1;
        q_wa       = TASK_W'(task_r);
        q_wd       = {(prev_r == LINK_NULL) ? nlink_r : qhead_r,
                      (qtail_r == cur_r) ? prev_r : qtail_r};
        status_nxt = mpme_pkg::ST_OK;
        state_nxt  = S_FREE_CUR;
      end
      S_FREE_CUR: begin
        lnk_we = 1'b1;
        lnk_wd = LINK_NULL;
        if (free_head_r == LINK_NULL) begin
          free_head_nxt = cur_r;
          free_tail_nxt = cur_r;
          state_nxt     = S_OUT;
        end else if (free_tail_r != LINK_NULL) begin
          state_nxt = S_FREE_TAIL;
        end else begin
          free_tail_nxt = cur_r;
          state_nxt     = S_OUT;
        end
      end
      S_FREE_TAIL: begin
        lnk_we        = 1'b1;
        lnk_wa        = free_tail_r[BUF_W-1:0];
        lnk_wd        = cur_r;
        free_tail_nxt = cur_r;
        state_nxt     = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = status_r;
          out_rx_size_nxt = rsize_r;
          out_rx_data_nxt = rdata_r;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      free_head_r <= '0;
      free_tail_r <= LINK_W'(NUM_BUFFERS - 1);
      out_valid_r <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      req_type_r    <= req_type_nxt;
      task_r        <= task_nxt;
      peer_r        <= peer_nxt;
      size_r        <= size_nxt;
      data_r        <= data_nxt;
      free_head_r   <= free_head_nxt;
      free_tail_r   <= free_tail_nxt;
      qhead_r       <= qhead_nxt;
      qtail_r       <= qtail_nxt;
      prev_r        <= prev_nxt;
      cur_r         <= cur_nxt;
      nlink_r       <= nlink_nxt;
      status_r      <= status_nxt;
      rsize_r       <= rsize_nxt;
      rdata_r       <= rdata_nxt;
      out_valid_r   <= out_valid_nxt;
      out_status_r  <= out_status_nxt;
      out_rx_size_r <= out_rx_size_nxt;
      out_rx_data_r <= out_rx_data_nxt;
    end
  end

  assign in_stall    = (state_r != S_IDLE);
  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_rx_size = out_rx_size_r;
  assign out_rx_data = out_rx_data_r;

`ifndef SYNTHESIS
  a_free_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> ((free_head_r == LINK_NULL) == (free_tail_r == LINK_NULL)))
    else $error("free list head and tail disagree on empty");

  a_link_port: assert property (@(posedge clk) disable iff (!rst_n)
    !(lnk_we && lnk_re))
    else $error("link memory read and write in one cycle");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != mpme_pkg::ST_OK) |->
    (out_rx_size_r == '0 && out_rx_data_r == '0))
    else $error("failed request carries message data");

  a_bad_id: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && in_valid && !ids_ok) |=>
    (state_r == S_OUT && status_r == mpme_pkg::ST_NO_MSG))
    else $error("out of range task not rejected");

  a_send_req: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SEND) |-> (req_type_r == mpme_pkg::REQ_SEND))
    else $error("send path entered for a receive request");
`endif

endmodule
